// ----- hdl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg
// widths and opcodes shared by the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int DEN_W         = OPERAND_WIDTH - 1;
    localparam int RES_W         = 2 * OPERAND_WIDTH;
    localparam int RES_DEN_W     = RES_W - 1;
    localparam int PROD_W        = 2 * (OPERAND_WIDTH + 1);
    localparam int CNT_W         = $clog2(RES_W);

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_NEG  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_IDIV = 3'd5
    } t_opcode;

endpackage

// ----- hdl/rau_if.sv -----
// ----------------------------------------------------------------------------
// rau_if
// operand and result channels of the rational arithmetic unit
// ----------------------------------------------------------------------------
interface rau_in_if;
    import rau_pkg::*;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      opcode;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic [DEN_W-1:0]                a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic [DEN_W-1:0]                b_den;

    modport source (output valid, opcode, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, opcode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    import rau_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_num;
    logic [RES_DEN_W-1:0]    res_den;
    logic signed [RES_W-1:0] rem_num;
    logic [RES_DEN_W-1:0]    rem_den;
    logic                    div_error;

    modport source (output valid, res_num, res_den, rem_num, rem_den, div_error,
                    input ready);
    modport sink   (input valid, res_num, res_den, rem_num, rem_den, div_error,
                    output ready);
endinterface

// ----- hdl/rational_arithmetic_unit_core.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// sequenced rational arithmetic: shared multiplier, binary gcd, shared divider
// ----------------------------------------------------------------------------
// sequence: products on the shared multiplier, setup, the integer quotient
// (integer divide only), binary gcd steps, then numerator and denominator divides
// one transaction at a time; division errors and unused opcodes are answered
// from idle, a zero numerator (remainder for idiv) skips the gcd and divides
// reset: synchronous active low, clears the sequencer and the output valid
module rational_arithmetic_unit_core
    import rau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_PREP = 8'b0000_0100,
        S_QDIV = 8'b0000_1000,
        S_RED  = 8'b0001_0000,
        S_GCD  = 8'b0010_0000,
        S_DIVN = 8'b0100_0000,
        S_DIVD = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [2:0] r_op;
    logic signed [OPERAND_WIDTH-1:0] r_an, r_bn;
    logic [DEN_W-1:0] r_ad, r_bd;
    logic [1:0] r_mi;
    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic r_neg;
    logic [RES_W-1:0] r_q, r_m, r_d, r_x, r_y, r_g;
    logic [CNT_W-1:0] r_k;
    logic [RES_W-1:0] r_dv_rem, r_dv_quo, r_dv_den;
    logic [CNT_W-1:0] r_cnt;
    logic r_out_valid, r_err;
    logic signed [RES_W-1:0] r_res_num, r_rem_num;
    logic [RES_DEN_W-1:0] r_res_den, r_rem_den;

    logic signed [OPERAND_WIDTH:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p, pn, pd;
    logic [RES_W:0] dv_part, dv_trial;
    logic [RES_W-1:0] dv_rem_n, dv_quo_n, q_signed, num_signed;
    logic dv_last;

    // shared multiplier operand selection
    always_comb begin
        mul_a = {r_an[OPERAND_WIDTH-1], r_an};
        mul_b = $signed({2'b00, r_bd});
        case (r_mi)
            2'd0: begin
                mul_a = {r_an[OPERAND_WIDTH-1], r_an};
                mul_b = (r_op == OP_MUL) ? {r_bn[OPERAND_WIDTH-1], r_bn}
                                         : $signed({2'b00, r_bd});
            end
            2'd1: begin
                mul_a = (r_op == OP_MUL) ? $signed({2'b00, r_bd})
                                         : {r_bn[OPERAND_WIDTH-1], r_bn};
                mul_b = $signed({2'b00, r_ad});
            end
            default: begin
                mul_a = $signed({2'b00, r_ad});
                mul_b = $signed({2'b00, r_bd});
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // numerator and denominator before reduction
    always_comb begin
        case (r_op)
            OP_ADD:  pn = r_p0 + r_p1;
            OP_SUB:  pn = r_p0 - r_p1;
            OP_NEG:  pn = -PROD_W'(r_an);
            default: pn = r_p0;
        endcase
        case (r_op)
            OP_ADD, OP_SUB: pd = r_p2;
            OP_NEG:         pd = $signed(PROD_W'(r_ad));
            default:        pd = r_p1;
        endcase
    end

    // restoring divider step
    always_comb begin
        dv_part  = {r_dv_rem, r_dv_quo[RES_W-1]};
        dv_trial = dv_part - {1'b0, r_dv_den};
        if (!dv_trial[RES_W]) begin
            dv_rem_n = dv_trial[RES_W-1:0];
            dv_quo_n = {r_dv_quo[RES_W-2:0], 1'b1};
        end else begin
            dv_rem_n = dv_part[RES_W-1:0];
            dv_quo_n = {r_dv_quo[RES_W-2:0], 1'b0};
        end
        dv_last    = (r_cnt == CNT_W'(RES_W - 1));
        q_signed   = r_neg ? -dv_quo_n : dv_quo_n;
        num_signed = r_neg ? -r_m : r_m;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_op  <= i_in.opcode;
                        r_an  <= i_in.a_num;
                        r_bn  <= i_in.b_num;
                        r_ad  <= (i_in.a_den == '0) ? DEN_W'(1) : i_in.a_den;
                        r_bd  <= (i_in.b_den == '0) ? DEN_W'(1) : i_in.b_den;
                        r_mi  <= 2'd0;
                        r_err <= 1'b0;
                        r_res_num <= '0;
                        r_res_den <= RES_DEN_W'(1);
                        r_rem_num <= '0;
                        r_rem_den <= RES_DEN_W'(1);
                        if ((i_in.opcode == OP_DIV || i_in.opcode == OP_IDIV)
                            && i_in.b_num == '0) begin
                            r_err       <= 1'b1;
                            r_out_valid <= 1'b1;
                        end else if (i_in.opcode > OP_IDIV) begin
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    case (r_mi)
                        2'd0:    r_p0 <= mul_p;
                        2'd1:    r_p1 <= mul_p;
                        default: r_p2 <= mul_p;
                    endcase
                    r_mi <= r_mi + 2'd1;
                    if (r_mi == 2'd2) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg <= pn[PROD_W-1] ^ pd[PROD_W-1];
                    r_m   <= pn[PROD_W-1] ? RES_W'(-pn) : RES_W'(pn);
                    r_d   <= pd[PROD_W-1] ? RES_W'(-pd) : RES_W'(pd);
                    if (r_op == OP_IDIV) begin
                        r_dv_quo <= pn[PROD_W-1] ? RES_W'(-pn) : RES_W'(pn);
                        r_dv_den <= pd[PROD_W-1] ? RES_W'(-pd) : RES_W'(pd);
                        r_dv_rem <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_QDIV;
                    end else begin
                        r_state <= S_RED;
                    end
                end
                S_QDIV: begin
                    r_dv_rem <= dv_rem_n;
                    r_dv_quo <= dv_quo_n;
                    r_cnt    <= r_cnt + CNT_W'(1);
                    if (dv_last) begin
                        r_q     <= q_signed;
                        r_m     <= dv_rem_n;
                        r_d     <= RES_W'(r_p2);
                        r_neg   <= r_p0[PROD_W-1];
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_m == '0) begin
                        if (r_op == OP_IDIV) begin
                            r_res_num <= r_q;
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_x     <= r_m;
                        r_y     <= r_d;
                        r_k     <= '0;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_x == r_y) begin
                        r_g      <= r_x << r_k;
                        r_dv_quo <= r_m;
                        r_dv_den <= r_x << r_k;
                        r_dv_rem <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_DIVN;
                    end else if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + CNT_W'(1);
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (r_x > r_y) begin
                        r_x <= (r_x - r_y) >> 1;
                    end else begin
                        r_y <= (r_y - r_x) >> 1;
                    end
                end
                S_DIVN: begin
                    if (dv_last) begin
                        r_m      <= dv_quo_n;
                        r_dv_quo <= r_d;
                        r_dv_den <= r_g;
                        r_dv_rem <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_DIVD;
                    end else begin
                        r_dv_rem <= dv_rem_n;
                        r_dv_quo <= dv_quo_n;
                        r_cnt    <= r_cnt + CNT_W'(1);
                    end
                end
                S_DIVD: begin
                    r_dv_rem <= dv_rem_n;
                    r_dv_quo <= dv_quo_n;
                    r_cnt    <= r_cnt + CNT_W'(1);
                    if (dv_last) begin
                        if (r_op == OP_IDIV) begin
                            r_res_num <= r_q;
                            r_rem_num <= num_signed;
                            r_rem_den <= dv_quo_n[RES_DEN_W-1:0];
                        end else begin
                            r_res_num <= num_signed;
                            r_res_den <= dv_quo_n[RES_DEN_W-1:0];
                        end
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready      = (r_state == S_IDLE) && !r_out_valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.res_num   = r_res_num;
    assign o_out.res_den   = r_res_den;
    assign o_out.rem_num   = r_rem_num;
    assign o_out.rem_den   = r_rem_den;
    assign o_out.div_error = r_err;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("ready while a transaction is in flight");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.res_den != '0 && o_out.rem_den != '0))
        else $error("zero denominator in result");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.div_error) |-> (o_out.res_num == '0 && o_out.rem_num == '0))
        else $error("nonzero result with division error");

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_x != '0 && r_y != '0))
        else $error("gcd operand reached zero");

endmodule

// ----- sim/rational_arithmetic_unit_core_test.sv -----
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_test
// drives random and corner-case operand pairs through the unit and compares
// every reduced result against a behavioural predictor, with random idling
// on both channels and a long result back-pressure stretch
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_test
    import rau_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [RES_W-1:0] res_num;
        logic [RES_DEN_W-1:0]    res_den;
        logic signed [RES_W-1:0] rem_num;
        logic [RES_DEN_W-1:0]    rem_den;
        logic                    div_error;
    } t_answer;

    function automatic longint gcd_of(longint x, longint y);
        longint t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic void lowest_terms(longint n, longint d, output longint on,
                                         output longint od);
        bit     neg;
        longint mn;
        longint md;
        longint g;
        neg = (n < 0) != (d < 0);
        mn  = n < 0 ? -n : n;
        md  = d < 0 ? -d : d;
        if (mn == 0 || md == 0) begin
            on = 0;
            od = 1;
        end else begin
            g  = gcd_of(mn, md);
            mn = mn / g;
            md = md / g;
            on = neg ? -mn : mn;
            od = md;
        end
    endfunction

    function automatic t_answer rational_result(logic [2:0] op, logic [15:0] an_r,
                                                logic [14:0] ad_r, logic [15:0] bn_r,
                                                logic [14:0] bd_r);
        longint  an, ad, bn, bd, rn, rd, qn, qd, n, d, q, mn, md;
        t_answer r;
        an = longint'($signed(an_r));
        bn = longint'($signed(bn_r));
        ad = ad_r == 0 ? 1 : longint'(ad_r);
        bd = bd_r == 0 ? 1 : longint'(bd_r);
        rn = 0; rd = 1; qn = 0; qd = 1;
        r.div_error = 1'b0;
        case (op)
            OP_ADD:  lowest_terms(an * bd + bn * ad, ad * bd, rn, rd);
            OP_SUB:  lowest_terms(an * bd - bn * ad, ad * bd, rn, rd);
            OP_NEG:  lowest_terms(-an, ad, rn, rd);
            OP_MUL:  lowest_terms(an * bn, ad * bd, rn, rd);
            OP_DIV: begin
                if (bn == 0) r.div_error = 1'b1;
                else lowest_terms(an * bd, ad * bn, rn, rd);
            end
            OP_IDIV: begin
                if (bn == 0) begin
                    r.div_error = 1'b1;
                end else begin
                    n  = an * bd;
                    d  = ad * bn;
                    mn = n < 0 ? -n : n;
                    md = d < 0 ? -d : d;
                    q  = mn / md;
                    if ((n < 0) != (d < 0)) q = -q;
                    rn = q;
                    rd = 1;
                    lowest_terms(n - q * d, ad * bd, qn, qd);
                end
            end
            default: ;
        endcase
        r.res_num = rn[RES_W-1:0];
        r.res_den = rd[RES_DEN_W-1:0];
        r.rem_num = qn[RES_W-1:0];
        r.rem_den = qd[RES_DEN_W-1:0];
        return r;
    endfunction

    class answer_board;
        t_answer pending[$];
        int      errors;

        function void note_operands(logic [2:0] op, logic [15:0] an, logic [14:0] ad,
                                    logic [15:0] bn, logic [14:0] bd);
            pending.push_back(rational_result(op, an, ad, bn, bd));
        endfunction

        function void check_answer(t_answer got);
            t_answer exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.res_num !== exp.res_num)
                $display("%0t res_num exp %0d got %0d", $time, exp.res_num, got.res_num);
            if (got.res_den !== exp.res_den)
                $display("%0t res_den exp %0d got %0d", $time, exp.res_den, got.res_den);
            if (got.rem_num !== exp.rem_num)
                $display("%0t rem_num exp %0d got %0d", $time, exp.rem_num, got.rem_num);
            if (got.rem_den !== exp.rem_den)
                $display("%0t rem_den exp %0d got %0d", $time, exp.rem_den, got.rem_den);
            if (got.div_error !== exp.div_error)
                $display("%0t div_error exp %0b got %0b", $time, exp.div_error,
                         got.div_error);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    rau_in_if    in_ch();
    rau_out_if   out_ch();
    answer_board board = new();
    int          send_idle_pct = 10;
    int          recv_idle_pct = 61;
    bit          hold_results = 1'b0;
    int          quiet_cycles = 0;
    int          watchdog_limit = 20000;

    rational_arithmetic_unit_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid  = 1'b0;
        in_ch.opcode = '0;
        in_ch.a_num  = '0;
        in_ch.a_den  = 15'd1;
        in_ch.b_num  = '0;
        in_ch.b_den  = 15'd1;
        out_ch.ready = 1'b0;
    end

    // result side and accounting
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_answer('{out_ch.res_num, out_ch.res_den, out_ch.rem_num,
                                 out_ch.rem_den, out_ch.div_error});
        if (i_rst_n && in_ch.valid && in_ch.ready)
            board.note_operands(in_ch.opcode, in_ch.a_num, in_ch.a_den, in_ch.b_num,
                                in_ch.b_den);
        out_ch.ready <= i_rst_n && !hold_results &&
                        ($urandom_range(99, 0) >= recv_idle_pct);
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > watchdog_limit) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_operands(logic [2:0] op, logic [15:0] an, logic [14:0] ad,
                                 logic [15:0] bn, logic [14:0] bd);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.a_num  <= an;
        in_ch.a_den  <= ad;
        in_ch.b_num  <= bn;
        in_ch.b_den  <= bd;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_random();
        logic [2:0]  op;
        logic [15:0] an, bn;
        logic [14:0] ad, bd;
        op = $urandom_range(99, 0) < 3 ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
        an = 16'($urandom);
        bn = $urandom_range(9, 0) == 0 ? 16'd0 : 16'($urandom);
        case ($urandom_range(3, 0))
            0: begin ad = 15'($urandom_range(12, 1)); bd = 15'($urandom_range(12, 1)); end
            1: begin ad = 15'($urandom); bd = 15'($urandom); end
            2: begin ad = 15'($urandom_range(32767, 1)); bd = ad; end
            default: begin
                ad = 15'($urandom_range(300, 1) * 6);
                bd = 15'($urandom_range(300, 1) * 4);
            end
        endcase
        if ($urandom_range(49, 0) == 0) ad = 15'd0;
        send_operands(op, an, ad, bn, bd);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int op = 0; op < 8; op++) begin
            send_operands(3'(op), 16'h7fff, 15'h7fff, 16'h8000, 15'd1);
            send_operands(3'(op), 16'h8000, 15'd1, 16'hffff, 15'h7fff);
            send_operands(3'(op), 16'd6, 15'd4, 16'd0, 15'd0);
        end
        send_operands(OP_IDIV, 16'hfff9, 15'd2, 16'd3, 15'd4);

        for (int i = 0; i < 220; i++) send_random();
        drain();

        // results held back while the sender keeps offering
        hold_results = 1'b1;
        fork
            repeat (600) @(posedge i_clk);
            for (int i = 0; i < 6; i++) send_random();
        join_any
        disable fork;
        hold_results = 1'b0;
        send_idle_pct = 61;
        recv_idle_pct = 10;
        for (int i = 0; i < 220; i++) send_random();
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 240; i++) send_random();
        drain();
        repeat (300) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- rational_arithmetic_unit_core.f -----
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rational_arithmetic_unit_core.sv
sim/rational_arithmetic_unit_core_test.sv
